// ----- design/ljpf_pkg.sv -----
package ljpf_pkg;

    localparam int POS_W     = 24;
    localparam int SQ_W      = 2 * POS_W;
    localparam int R2_W      = SQ_W + 2;
    localparam int Q_W       = 64;
    localparam int OUT_W     = 32;
    localparam int DIV_STEPS = Q_W;
    localparam int AXES      = 3;

    // register index of each pipeline stage
    localparam int DIV_FIRST = 3;
    localparam int DIV_LAST  = DIV_FIRST + DIV_STEPS - 1;
    localparam int FIN_IDX   = DIV_LAST + 18;

    localparam logic [1:0] CFG_BOX_SIZE  = 2'd0;
    localparam logic [1:0] CFG_CUTOFF_SQ = 2'd1;
    localparam logic [1:0] CFG_E_SHIFT   = 2'd2;

    localparam logic [7:0]        BOX_RST   = 8'd10;
    localparam logic [23:0]       CUT_RST   = 24'd409600;
    localparam logic signed [31:0] SHIFT_RST = -32'sd1069;

    typedef struct packed {
        logic                        in_range;
        logic [AXES-1:0]             neg;
        logic [AXES-1:0][POS_W-1:0]  mag;
    } side_t;

    typedef struct packed {
        logic           neg;
        logic [Q_W-1:0] mag;
    } sdiff_t;

    function automatic logic [Q_W-1:0] sat_mulk(input logic [Q_W-1:0] a,
                                                 input logic [6:0] k);
        logic [Q_W+6:0] prod;
        prod = (Q_W+7)'(a) * (Q_W+7)'(k);
        return (prod[Q_W+6:Q_W] != '0) ? '1 : prod[Q_W-1:0];
    endfunction

    // saturated minuend stays saturated and positive
    function automatic sdiff_t sat_diff(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
        sdiff_t r;
        if (a == '1) begin
            r.neg = 1'b0;
            r.mag = '1;
        end else if (a >= b) begin
            r.neg = 1'b0;
            r.mag = a - b;
        end else begin
            r.neg = 1'b1;
            r.mag = b - a;
        end
        return r;
    endfunction

endpackage

// ----- design/ljpf_mulq.sv -----
module ljpf_mulq
    import ljpf_pkg::*;
(
    input  logic           clk,
    input  logic           en,
    input  logic [Q_W-1:0] a,
    input  logic [Q_W-1:0] b,
    output logic [Q_W-1:0] p
);

    logic [63:0] hh_reg, hl_reg, lh_reg, ll_reg;
    logic [65:0] mid_reg;
    logic [31:0] hh_lo_reg;
    logic        hh_big_reg;
    logic [66:0] total;
    logic [65:0] mid_next;

    assign mid_next = 66'(hl_reg) + 66'(lh_reg) + 66'(ll_reg[63:32]);
    assign total    = {3'b0, hh_lo_reg, 32'b0} + 67'(mid_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg     <= a[63:32] * b[63:32];
            hl_reg     <= a[63:32] * b[31:0];
            lh_reg     <= a[31:0] * b[63:32];
            ll_reg     <= a[31:0] * b[31:0];
            mid_reg    <= mid_next;
            hh_lo_reg  <= hh_reg[31:0];
            hh_big_reg <= (hh_reg[63:32] != '0);
            p          <= (hh_big_reg || total[66:64] != '0) ? '1 : total[63:0];
        end
    end

endmodule

// ----- design/lj_pair_force_min_image_unit.sv -----
// Throughput: one pair per cycle; the 64-stage reciprocal divider and the
//   chain of 3-stage saturating 64x64 multipliers are fully pipelined.
// A stalled output holds the pipeline only when its last stage is full.
// Reset (rst_n low, asynchronous): drop all requests in flight, clear
//   output valid, return box_size, cutoff_squared, energy_shift to defaults.
module lj_pair_force_min_image_unit
    import ljpf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // s_tdata: first_x, first_y, first_z, second_x, second_y, second_z
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,
    // m_tdata: force_x, force_y, force_z, pair_energy
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,
    // m_tuser: in_range, saturated
    output logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    // configuration
    logic [7:0]         box_reg;
    logic [23:0]        cut_reg;
    logic signed [31:0] shift_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg   <= BOX_RST;
            cut_reg   <= CUT_RST;
            shift_reg <= SHIFT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BOX_SIZE:  box_reg   <= cfg_data[7:0];
                CFG_CUTOFF_SQ: cut_reg   <= cfg_data[23:0];
                CFG_E_SHIFT:   shift_reg <= $signed(cfg_data);
                default:       ;
            endcase
        end
    end

    // flow control: advance everything unless the last stage is stuck
    logic                en;
    logic [FIN_IDX:0]    vld_reg;
    logic                out_valid_reg;
    logic                out_load;

    assign en       = !vld_reg[FIN_IDX] || !out_valid_reg || m_tready;
    assign s_tready = en;
    assign out_load = vld_reg[FIN_IDX] && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
                vld_reg <= {vld_reg[FIN_IDX-1:0], s_tvalid};
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // stage 0: displacement and minimum-image fold
    logic [AXES-1:0][POS_W-1:0] pos_a, pos_b;
    logic signed [POS_W:0]      diff   [AXES];
    logic [POS_W-1:0]           dabs   [AXES];
    logic signed [POS_W+1:0]    fold_m [AXES];
    logic [POS_W-1:0]           box_len;
    side_t                      side_in;
    side_t                      side_reg [FIN_IDX+1];

    assign pos_a   = s_tdata[71:0];
    assign pos_b   = s_tdata[143:72];
    assign box_len = {box_reg, 16'b0};

    always_comb
    begin
        side_in = '0;
        for (int i = 0; i < AXES; i++)
        begin
            diff[i]   = $signed({1'b0, pos_a[i]}) - $signed({1'b0, pos_b[i]});
            dabs[i]   = diff[i][POS_W] ? POS_W'(-diff[i]) : diff[i][POS_W-1:0];
            fold_m[i] = $signed({2'b0, box_len}) - $signed({2'b0, dabs[i]});
            if ({dabs[i], 1'b0} > {1'b0, box_len})
            begin
                // wrap: flip the direction toward the nearer image
                side_in.neg[i] = diff[i][POS_W] ? fold_m[i][POS_W+1]
                               : (!fold_m[i][POS_W+1] && fold_m[i] != '0);
                side_in.mag[i] = fold_m[i][POS_W+1] ? POS_W'(-fold_m[i])
                               : fold_m[i][POS_W-1:0];
            end
            else
            begin
                side_in.neg[i] = diff[i][POS_W];
                side_in.mag[i] = dabs[i];
            end
        end
    end

    // stages 1-2: squares, r squared, cutoff compare
    logic [SQ_W-1:0] sq_reg [AXES];
    logic [R2_W-1:0] r2_sum;
    logic [R2_W-1:0] r2_reg;
    side_t           side_rng;

    assign r2_sum = R2_W'(sq_reg[0]) + R2_W'(sq_reg[1]) + R2_W'(sq_reg[2]);

    // merge the cutoff decision into the side data entering stage 2
    always_comb
    begin
        side_rng          = side_reg[1];
        side_rng.in_range = (r2_sum <= R2_W'({cut_reg, 16'b0}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k <= FIN_IDX; k++)
                side_reg[k] <= (k == 2) ? side_rng : side_reg[k-1];
            for (int i = 0; i < AXES; i++)
                sq_reg[i] <= SQ_W'(side_reg[0].mag[i]) * SQ_W'(side_reg[0].mag[i]);
            r2_reg <= r2_sum;
        end
    end

    // reciprocal: restoring division of all ones by r squared, one bit a stage;
    // a zero divisor yields all ones
    logic [R2_W-1:0] div_rem_reg [DIV_STEPS];
    logic [R2_W-1:0] div_d_reg   [DIV_STEPS];
    logic [Q_W-1:0]  div_q_reg   [DIV_STEPS];
    logic [R2_W-1:0] div_rem_next [DIV_STEPS];
    logic [Q_W-1:0]  div_q_next   [DIV_STEPS];
    logic [R2_W-1:0] div_d_in     [DIV_STEPS];
    logic [R2_W:0]   div_sh       [DIV_STEPS];
    logic            div_ge       [DIV_STEPS];

    always_comb
    begin
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            div_d_in[j] = (j == 0) ? r2_reg : div_d_reg[j-1];
            div_sh[j]   = (j == 0) ? {{R2_W{1'b0}}, 1'b1} : {div_rem_reg[j-1], 1'b1};
            div_ge[j]   = div_sh[j] >= {1'b0, div_d_in[j]};
            div_rem_next[j] = div_ge[j] ? R2_W'(div_sh[j] - {1'b0, div_d_in[j]})
                                        : div_sh[j][R2_W-1:0];
            div_q_next[j] = (j == 0) ? Q_W'(div_ge[j])
                                     : {div_q_reg[j-1][Q_W-2:0], div_ge[j]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                div_rem_reg[j] <= div_rem_next[j];
                div_d_reg[j]   <= div_d_in[j];
                div_q_reg[j]   <= div_q_next[j];
            end
        end
    end

    // power chain: s2, then s3 and s4, then s6, then s7
    logic [Q_W-1:0] s_val, s2, s3, s4, s6, s7;
    logic [Q_W-1:0] s_dly_reg  [9];
    logic [Q_W-1:0] s3_dly_reg [6];
    logic [Q_W-1:0] s4_dly_reg [6];
    logic [Q_W-1:0] s6_dly_reg [3];

    assign s_val = div_q_reg[DIV_STEPS-1];

    ljpf_mulq u_mul_s2 (.clk(clk), .en(en), .a(s_val), .b(s_val), .p(s2));
    ljpf_mulq u_mul_s3 (.clk(clk), .en(en), .a(s2), .b(s_dly_reg[2]), .p(s3));
    ljpf_mulq u_mul_s4 (.clk(clk), .en(en), .a(s2), .b(s2), .p(s4));
    ljpf_mulq u_mul_s6 (.clk(clk), .en(en), .a(s3), .b(s3), .p(s6));
    ljpf_mulq u_mul_s7 (.clk(clk), .en(en), .a(s6), .b(s_dly_reg[8]), .p(s7));

    // constant multiples, then force and energy magnitudes
    logic [Q_W-1:0]  k48_reg, k24_reg, e6_reg, e3_reg;
    sdiff_t          fdiff, ediff;
    logic [Q_W-1:0]  fmag_reg;
    logic            fneg_reg;
    logic [47:0]     emag_reg;
    logic            eneg_reg;
    logic [47:0]     emag_dly_reg [3];
    logic            eneg_dly_reg [3];
    logic            fneg_dly_reg [3];

    assign fdiff = sat_diff(k48_reg, k24_reg);
    assign ediff = sat_diff(e6_reg, e3_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_dly_reg[0] <= s_val;
            for (int k = 1; k < 9; k++)
                s_dly_reg[k] <= s_dly_reg[k-1];
            s3_dly_reg[0] <= s3;
            s4_dly_reg[0] <= s4;
            for (int k = 1; k < 6; k++)
            begin
                s3_dly_reg[k] <= s3_dly_reg[k-1];
                s4_dly_reg[k] <= s4_dly_reg[k-1];
            end
            s6_dly_reg[0] <= s6;
            for (int k = 1; k < 3; k++)
                s6_dly_reg[k] <= s6_dly_reg[k-1];

            k48_reg <= sat_mulk(s7, 7'd48);
            k24_reg <= sat_mulk(s4_dly_reg[5], 7'd24);
            e6_reg  <= sat_mulk(s6_dly_reg[2], 7'd4);
            e3_reg  <= sat_mulk(s3_dly_reg[5], 7'd4);

            fmag_reg <= fdiff.mag;
            fneg_reg <= fdiff.neg;
            emag_reg <= ediff.mag[63:16];
            eneg_reg <= ediff.neg;

            emag_dly_reg[0] <= emag_reg;
            eneg_dly_reg[0] <= eneg_reg;
            fneg_dly_reg[0] <= fneg_reg;
            for (int k = 1; k < 3; k++)
            begin
                emag_dly_reg[k] <= emag_dly_reg[k-1];
                eneg_dly_reg[k] <= eneg_dly_reg[k-1];
                fneg_dly_reg[k] <= fneg_dly_reg[k-1];
            end
        end
    end

    // force components: |f| times |d| per axis
    logic [Q_W-1:0] fprod [AXES];

    for (genvar g = 0; g < AXES; g++)
    begin : g_force
        ljpf_mulq u_mul_f (
            .clk (clk),
            .en  (en),
            .a   (fmag_reg),
            .b   (Q_W'(side_reg[FIN_IDX-4].mag[g])),
            .p   (fprod[g])
        );
    end

    // final stage: cap, sign, clip, energy shift, out-of-range zeroing
    localparam logic [40:0] PCAP = 41'h100_0000_0000;

    logic [40:0]        pcap   [AXES];
    logic               fsign  [AXES];
    logic [OUT_W-1:0]   fval   [AXES];
    logic [AXES-1:0]    fclip;
    logic signed [49:0] e_signed;
    logic signed [50:0] e_total;
    logic [OUT_W-1:0]   e_val;
    logic               e_clip;
    side_t              side_fin;
    logic [OUT_W-1:0]   fin_f_reg [AXES];
    logic [OUT_W-1:0]   fin_e_reg;
    logic               fin_rng_reg, fin_sat_reg;

    assign side_fin = side_reg[FIN_IDX-1];

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            pcap[i]  = (fprod[i] > Q_W'(PCAP)) ? PCAP : fprod[i][40:0];
            fsign[i] = fneg_dly_reg[2] ^ side_fin.neg[i];
            if (!fsign[i])
            begin
                fclip[i] = pcap[i] > 41'h0_7FFF_FFFF;
                fval[i]  = fclip[i] ? 32'h7FFF_FFFF : pcap[i][31:0];
            end
            else
            begin
                fclip[i] = pcap[i] > 41'h0_8000_0000;
                fval[i]  = fclip[i] ? 32'h8000_0000 : 32'(-pcap[i]);
            end
        end
        e_signed = eneg_dly_reg[2] ? -$signed({2'b0, emag_dly_reg[2]})
                                   : $signed({2'b0, emag_dly_reg[2]});
        e_total  = 51'(e_signed) - 51'(shift_reg);
        if (e_total > 51'sd2147483647)
        begin
            e_clip = 1'b1;
            e_val  = 32'h7FFF_FFFF;
        end
        else if (e_total < -51'sd2147483648)
        begin
            e_clip = 1'b1;
            e_val  = 32'h8000_0000;
        end
        else
        begin
            e_clip = 1'b0;
            e_val  = e_total[31:0];
        end
    end

    logic [OUT_W-1:0] out_f_reg [AXES];
    logic [OUT_W-1:0] out_e_reg;
    logic             out_rng_reg, out_sat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < AXES; i++)
                fin_f_reg[i] <= side_fin.in_range ? fval[i] : '0;
            fin_e_reg   <= side_fin.in_range ? e_val : '0;
            fin_rng_reg <= side_fin.in_range;
            fin_sat_reg <= side_fin.in_range && (fclip != '0 || e_clip);
        end
        if (out_load)
        begin
            for (int i = 0; i < AXES; i++)
                out_f_reg[i] <= fin_f_reg[i];
            out_e_reg   <= fin_e_reg;
            out_rng_reg <= fin_rng_reg;
            out_sat_reg <= fin_sat_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_e_reg, out_f_reg[2], out_f_reg[1], out_f_reg[0]};
    assign m_tuser  = {out_sat_reg, out_rng_reg};

endmodule

// ----- design/ljpf_checker.sv -----
module ljpf_checker
    import ljpf_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [1:0]   m_tuser
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // input backpressure only behind a stalled output
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

    // out of range gives all zeros and no clip
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("out-of-range result not zero");

    // clipping only happens within range
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("saturated without in_range");

endmodule

bind lj_pair_force_min_image_unit ljpf_checker u_ljpf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- bench/lj_pair_force_min_image_unit_test.sv -----
`timescale 1ns / 100ps

module lj_pair_force_min_image_unit_test;
    import ljpf_pkg::*;

    localparam int LATENCY = 85;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] force_x;
        logic [31:0] force_y;
        logic [31:0] force_z;
        logic [31:0] pair_energy;
        logic        in_range;
        logic        saturated;
    } pair_result_t;

    // Saturating Q32.32 product: floor(a*b/2^32), clipped to 2^64-1
    function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if (p[127:96] != 32'd0)
            return ALL_ONES;
        return p[95:32];
    endfunction

    function automatic logic [63:0] k_mul(input logic [63:0] a, input int unsigned k);
        logic [71:0] p;
        p = {8'd0, a} * 72'(k);
        return (p[71:64] != 8'd0) ? ALL_ONES : p[63:0];
    endfunction

    // Difference as sign and magnitude, saturated minuend stays saturated
    function automatic logic [64:0] signed_gap(input logic [63:0] a, input logic [63:0] b);
        if (a == ALL_ONES)
            return {1'b0, ALL_ONES};
        if (a >= b)
            return {1'b0, a - b};
        return {1'b1, b - a};
    endfunction

    function automatic logic signed [63:0] clip_word(input logic signed [63:0] v,
                                                     inout logic hit);
        if (v > 64'sd2147483647)
        begin
            hit = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            hit = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    class force_scoreboard;
        logic [7:0]         box_edge;
        logic [23:0]        cut_sq;
        logic signed [31:0] e_shift;
        pair_result_t       pending[$];
        int                 mismatches;
        int                 checked;

        function new();
            box_edge = BOX_RST;
            cut_sq = CUT_RST;
            e_shift = SHIFT_RST;
            mismatches = 0;
            checked = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] val);
            if (idx == CFG_BOX_SIZE)
                box_edge = val[7:0];
            else if (idx == CFG_CUTOFF_SQ)
                cut_sq = val[23:0];
            else if (idx == CFG_E_SHIFT)
                e_shift = val;
        endfunction

        // Predict the force and energy of one pair and queue them
        function void note_pair(logic [143:0] pos);
            pair_result_t r;
            logic signed [63:0] d[3];
            logic [63:0] mag[3];
            logic signed [63:0] edge_q, v, a, fv, e;
            logic [63:0] r2, s, s2, s3, s4, s6, s7, p, emag;
            logic [64:0] fd, ed;
            logic hit;
            r = '0;
            r2 = 0;
            hit = 1'b0;
            edge_q = 64'(box_edge) << 16;
            for (int i = 0; i < 3; i++)
            begin
                v = 64'(pos[i*24 +: 24]) - 64'(pos[(i+3)*24 +: 24]);
                a = (v < 0) ? -v : v;
                if (2 * a > edge_q)
                    v = (v > 0) ? -(edge_q - a) : (edge_q - a);
                d[i] = v;
                mag[i] = (v < 0) ? -v : v;
                r2 += mag[i] * mag[i];
            end
            if (r2 <= (64'(cut_sq) << 16))
            begin
                r.in_range = 1'b1;
                s = (r2 != 0) ? ALL_ONES / r2 : ALL_ONES;
                s2 = q_mul(s, s);
                s3 = q_mul(s2, s);
                s4 = q_mul(s2, s2);
                s6 = q_mul(s3, s3);
                s7 = q_mul(s6, s);
                fd = signed_gap(k_mul(s7, 48), k_mul(s4, 24));
                for (int i = 0; i < 3; i++)
                begin
                    p = q_mul(fd[63:0], mag[i]);
                    if (p > (64'd1 << 40))
                        p = 64'd1 << 40;
                    fv = (fd[64] != (d[i] < 0)) ? -$signed(p) : $signed(p);
                    fv = clip_word(fv, hit);
                    if (i == 0) r.force_x = fv[31:0];
                    if (i == 1) r.force_y = fv[31:0];
                    if (i == 2) r.force_z = fv[31:0];
                end
                ed = signed_gap(k_mul(s6, 4), k_mul(s3, 4));
                emag = ed[63:0] >> 16;
                e = ed[64] ? -$signed(emag) : $signed(emag);
                e = clip_word(e - 64'(e_shift), hit);
                r.pair_energy = e[31:0];
                r.saturated = hit;
            end
            pending.push_back(r);
        endfunction

        function void check_result(pair_result_t got);
            pair_result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected fx=%h fy=%h fz=%h e=%h r=%b s=%b, got fx=%h fy=%h fz=%h e=%h r=%b s=%b",
                             want.force_x, want.force_y, want.force_z, want.pair_energy,
                             want.in_range, want.saturated, got.force_x, got.force_y,
                             got.force_z, got.pair_energy, got.in_range, got.saturated);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    force_scoreboard board;
    bit              sending_done;
    int              pairs_sent;
    int              in_range_seen;

    lj_pair_force_min_image_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Random gap length: mostly none or short, now and then long
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Write one register; only called while the pipeline is empty
    task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        board.set_register(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Present one pair request and hold it until accepted
    task automatic send_pair(input logic [143:0] pos);
        int g;
        g = gap_len();
        // drop valid only while waiting out a gap
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pos;
        do @(posedge clk); while (!s_tready);
        board.note_pair(pos);
        pairs_sent++;
    endtask

    // Wait until every queued result has returned, then let the pipe drain
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Pair near the first particle, offset by up to reach/2 either way on each axis
    function automatic logic [143:0] near_pair(int reach);
        logic [23:0] a[3], b[3];
        for (int i = 0; i < 3; i++)
        begin
            a[i] = 24'($urandom());
            b[i] = a[i] + 24'($urandom_range(0, reach)) - 24'(reach / 2);
        end
        return {b[2], b[1], b[0], a[2], a[1], a[0]};
    endfunction

    function automatic logic [143:0] wild_pair();
        return 144'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    endfunction

    // Draw a pair whose coordinates live inside a box of the given edge
    function automatic logic [143:0] boxed_pair(int edge_len);
        logic [143:0] v;
        int lim;
        lim = (edge_len << 16) - 1;
        if (lim <= 0) lim = 1;
        for (int i = 0; i < 6; i++)
            v[i*24 +: 24] = 24'($urandom_range(0, lim));
        return v;
    endfunction

    task automatic random_phase(input int count, input int edge_len);
        int kind;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
                send_pair(near_pair(3 << 16));
            else if (kind < 7)
                send_pair(near_pair(1 << 15));
            else if (kind < 9)
                send_pair(boxed_pair(edge_len));
            else
                send_pair(wild_pair());
        end
    endtask

    // Output side: random stalls, checked at each accepted result
    initial
    begin
        pair_result_t got;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.force_x = m_tdata[31:0];
                got.force_y = m_tdata[63:32];
                got.force_z = m_tdata[95:64];
                got.pair_energy = m_tdata[127:96];
                got.in_range = m_tuser[0];
                got.saturated = m_tuser[1];
                if (got.in_range) in_range_seen++;
                board.check_result(got);
            end
            if ($urandom_range(0, 99) < 20)
                m_tready <= 1'b0;
            else if ($urandom_range(0, 99) < 3)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(8, 40)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Stimulus
    initial
    begin
        logic [143:0] v;
        board = new();
        sending_done = 0;
        pairs_sent = 0;
        in_range_seen = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_BOX_SIZE;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, coincident, field extremes, folding
        send_pair('0);
        send_pair('1);
        send_pair({24'd0, 24'd0, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF});
        send_pair({24'd0, 24'd0, 24'h010000, 24'd0, 24'd0, 24'd0});
        send_pair({24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'h010000});
        send_pair({24'd0, 24'h018000, 24'd0, 24'd0, 24'd0, 24'd0});
        send_pair({24'd0, 24'd0, 24'd1, 24'd0, 24'd0, 24'd0});
        send_pair({24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'h090000});
        send_pair({24'h090000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0});
        send_pair({24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'h050000});
        send_pair({24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'h028000});
        send_pair({24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'h028001});
        send_pair({24'h110000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0});
        send_pair({24'h00C000, 24'h00C000, 24'h00C000, 24'd0, 24'd0, 24'd0});
        drain_pipe();
        random_phase(400, 10);
        // Sender holds off until every result is back
        drain_pipe();

        // Box extremes and cutoff/shift extremes
        write_register(CFG_BOX_SIZE, 32'd0);
        write_register(CFG_CUTOFF_SQ, 32'hFFFFFF);
        write_register(CFG_E_SHIFT, 32'h7FFFFFFF);
        send_pair({24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'h020000});
        random_phase(300, 4);
        drain_pipe();

        write_register(CFG_BOX_SIZE, 32'd255);
        write_register(CFG_CUTOFF_SQ, 32'd0);
        write_register(CFG_E_SHIFT, 32'h80000000);
        send_pair('0);
        send_pair({24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd1});
        random_phase(250, 255);
        drain_pipe();

        write_register(CFG_BOX_SIZE, 32'd1);
        write_register(CFG_CUTOFF_SQ, 32'd20000);
        write_register(CFG_E_SHIFT, 32'd0);
        random_phase(300, 1);
        drain_pipe();

        write_register(CFG_BOX_SIZE, 32'($urandom_range(2, 40)));
        write_register(CFG_CUTOFF_SQ, 32'($urandom_range(65536, 1048576)));
        write_register(CFG_E_SHIFT, $urandom());
        random_phase(480, 20);
        s_tvalid <= 1'b0;
        sending_done = 1;
    end

    // End of run once everything has come back
    initial
    begin
        wait (sending_done);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        $display("Sent %0d pairs and checked %0d results (%0d within cutoff) over five register settings.",
                 pairs_sent, board.checked, in_range_seen);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Run timed out.");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
